### rtl/pts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg
// shared types, codes and helpers of the priority thread scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int THREAD_COUNT = 32;
    localparam int PRIO_W       = 6;
    localparam int ADDR_W       = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam int TICKS_W      = 32;
    localparam int ACT_W        = 2;
    localparam int STAT_W       = 2;
    localparam int MASK_W       = 32;

    typedef logic [ACT_W-1:0]        action_t;
    typedef logic [PRIO_W-1:0]       prio_t;
    typedef logic [TICKS_W-1:0]      ticks_t;
    typedef logic [STAT_W-1:0]       status_t;
    typedef logic [THREAD_COUNT-1:0] mask_t;

    // action codes
    localparam action_t ACT_START  = 2'd0;
    localparam action_t ACT_DELAY  = 2'd1;
    localparam action_t ACT_TICK   = 2'd2;
    localparam action_t ACT_SWITCH = 2'd3;

    // status codes
    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_IN_USE     = 2'd1;
    localparam status_t ST_IDLE_DELAY = 2'd2;
    localparam status_t ST_ZERO_TICKS = 2'd3;

    // highest set bit as a priority, 0 when the mask is empty
    function automatic prio_t highest_prio(input mask_t m);
        prio_t p;
        p = '0;
        for (int i = 0; i < THREAD_COUNT; i++)
        begin
            if (m[i])
            begin
                p = PRIO_W'(i + 1);
            end
        end
        return p;
    endfunction

endpackage
`default_nettype wire

### rtl/pts_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_if
// valid/ready channels for scheduler actions and scheduler results
// ----------------------------------------------------------------------------
interface pts_in_if;
    logic                valid;
    logic                ready;
    pts_pkg::action_t    action;
    pts_pkg::prio_t      priority_req;
    pts_pkg::ticks_t     ticks;

    modport source (output valid, output action, output priority_req, output ticks,
                    input ready);
    modport sink   (input valid, input action, input priority_req, input ticks,
                    output ready);
endinterface

interface pts_out_if;
    logic                         valid;
    logic                         ready;
    pts_pkg::prio_t               next_thread;
    logic                         switch_request;
    pts_pkg::status_t             status;
    logic [pts_pkg::MASK_W-1:0]   ready_set;

    modport source (output valid, output next_thread, output switch_request,
                    output status, output ready_set, input ready);
    modport sink   (input valid, input next_thread, input switch_request,
                    input status, input ready_set, output ready);
endinterface
`default_nettype wire

### rtl/priority_thread_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_thread_scheduler
// bitmap priority scheduler for prioritized threads plus idle, with tick delays
//
// result: start, delay and switch beats go to the finish state, which waits for a
//   free result slot and loads the result register; a tick beat first walks the
//   timeout ram, reading one entry per thread and writing back each blocked entry
//   once its read data is registered, then lets the read pipe empty before finish
// flow: one beat in flight at a time; the input stays closed until the result loads
// reset: asynchronous, clears masks, current thread and pick; timeout ram is
//   not cleared, no clearing pass is needed
// ----------------------------------------------------------------------------
module priority_thread_scheduler (
    input  wire           clk,
    input  wire           rst_n,
    pts_in_if.sink        in_ch,
    pts_out_if.source     out_ch
);

    // fsm codes
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_TICK   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    localparam int TC = pts_pkg::THREAD_COUNT;
    localparam int PW = pts_pkg::PRIO_W;
    localparam int AW = pts_pkg::ADDR_W;

    // control state
    logic [1:0]             state_reg, state_next;
    pts_pkg::mask_t         ready_reg, ready_next;
    pts_pkg::mask_t         blocked_reg, blocked_next;
    logic [TC:0]            registered_reg, registered_next;
    pts_pkg::prio_t         current_reg, current_next;
    pts_pkg::prio_t         next_pick_reg, next_pick_next;
    pts_pkg::status_t       status_reg, status_next;
    logic [PW-1:0]          tick_idx_reg, tick_idx_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [AW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   out_valid_reg, out_valid_next;

    // result payload, loaded when a beat finishes
    pts_pkg::prio_t         out_thread_reg;
    logic                   out_switch_reg;
    pts_pkg::status_t       out_status_reg;
    pts_pkg::mask_t         out_mask_reg;

    // timeout ram: one write port, one read port, registered read data
    pts_pkg::ticks_t        timeout_mem [TC];
    pts_pkg::ticks_t        rd_data_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [AW-1:0]          mem_ra;
    pts_pkg::ticks_t        mem_wd;

    // helpers
    logic [TC:0]            reg_shift;
    pts_pkg::prio_t         prio_m1;
    pts_pkg::prio_t         cur_m1;
    pts_pkg::ticks_t        dec_val;
    pts_pkg::prio_t         pick;
    logic                   out_load;

    assign reg_shift = registered_reg >> in_ch.priority_req;
    assign prio_m1   = in_ch.priority_req - PW'(1);
    assign cur_m1    = current_reg - PW'(1);
    assign dec_val   = rd_data_reg - pts_pkg::TICKS_W'(1);
    assign pick      = pts_pkg::highest_prio(ready_reg);

    // one beat in flight at a time; the result register parts the output side
    assign in_ch.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        ready_next      = ready_reg;
        blocked_next    = blocked_reg;
        registered_next = registered_reg;
        current_next    = current_reg;
        next_pick_next  = next_pick_reg;
        status_next     = status_reg;
        tick_idx_next   = tick_idx_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_load        = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = '0;
        mem_wd          = '0;
        mem_ra          = tick_idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    status_next = pts_pkg::ST_OK;
                    state_next  = S_FINISH;
                    case (in_ch.action)
                        pts_pkg::ACT_START:
                        begin
                            // out of range counts as already in use
                            if (in_ch.priority_req > PW'(TC) || reg_shift[0])
                            begin
                                status_next = pts_pkg::ST_IN_USE;
                            end
                            else
                            begin
                                registered_next = registered_reg
                                    | ((TC + 1)'(1) << in_ch.priority_req);
                                // idle gets registered but never marked ready
                                if (in_ch.priority_req != '0)
                                begin
                                    ready_next = ready_reg | (TC'(1) << prio_m1);
                                end
                            end
                        end
                        pts_pkg::ACT_DELAY:
                        begin
                            if (current_reg == '0 || current_reg > PW'(TC))
                            begin
                                status_next = pts_pkg::ST_IDLE_DELAY;
                            end
                            else if (in_ch.ticks == '0)
                            begin
                                status_next = pts_pkg::ST_ZERO_TICKS;
                            end
                            else
                            begin
                                mem_we       = 1'b1;
                                mem_wa       = cur_m1[AW-1:0];
                                mem_wd       = in_ch.ticks;
                                ready_next   = ready_reg & ~(TC'(1) << cur_m1);
                                blocked_next = blocked_reg | (TC'(1) << cur_m1);
                            end
                        end
                        pts_pkg::ACT_TICK:
                        begin
                            tick_idx_next = '0;
                            state_next    = S_TICK;
                        end
                        pts_pkg::ACT_SWITCH:
                        begin
                            current_next = next_pick_reg;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_TICK:
            begin
                // write-back stage: decrement the entry read last cycle
                if (rd_vld_reg && blocked_reg[rd_idx_reg])
                begin
                    mem_we = 1'b1;
                    mem_wa = rd_idx_reg;
                    mem_wd = dec_val;
                    if (dec_val == '0)
                    begin
                        ready_next[rd_idx_reg]   = 1'b1;
                        blocked_next[rd_idx_reg] = 1'b0;
                    end
                end
                // read stage: issue the next entry, write and read never collide
                if (tick_idx_reg < PW'(TC))
                begin
                    rd_vld_next   = 1'b1;
                    rd_idx_next   = tick_idx_reg[AW-1:0];
                    tick_idx_next = tick_idx_reg + PW'(1);
                end
                else if (!rd_vld_reg)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // wait for a free result slot, then re-pick and report
                if (!out_valid_reg || out_ch.ready)
                begin
                    next_pick_next = pick;
                    out_valid_next = 1'b1;
                    out_load       = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ready_reg      <= '0;
            blocked_reg    <= '0;
            registered_reg <= '0;
            current_reg    <= '0;
            next_pick_reg  <= '0;
            status_reg     <= pts_pkg::ST_OK;
            tick_idx_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ready_reg      <= ready_next;
            blocked_reg    <= blocked_next;
            registered_reg <= registered_next;
            current_reg    <= current_next;
            next_pick_reg  <= next_pick_next;
            status_reg     <= status_next;
            tick_idx_reg   <= tick_idx_next;
            rd_vld_reg     <= rd_vld_next;
            rd_idx_reg     <= rd_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_thread_reg <= pick;
            out_switch_reg <= (pick != current_reg);
            out_status_reg <= status_reg;
            out_mask_reg   <= ready_reg;
        end
    end

    // timeout ram
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            timeout_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= timeout_mem[mem_ra];
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.next_thread    = out_thread_reg;
    assign out_ch.switch_request = out_switch_reg;
    assign out_ch.status         = out_status_reg;
    assign out_ch.ready_set      = pts_pkg::MASK_W'(out_mask_reg);

endmodule
`default_nettype wire

### rtl/pts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_checker
// port-level checks of the priority thread scheduler, bound to the top level
// ----------------------------------------------------------------------------
module pts_checker (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    input  wire                             in_ready,
    input  wire                             out_valid,
    input  wire                             out_ready,
    input  wire [pts_pkg::PRIO_W-1:0]       next_thread,
    input  wire                             switch_request,
    input  wire [pts_pkg::STAT_W-1:0]       status,
    input  wire [pts_pkg::MASK_W-1:0]       ready_set
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_thread)
            && $stable(switch_request) && $stable(status) && $stable(ready_set))
        else $error("result beat changed while stalled");

    // one beat in flight: input closes after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input stayed open after accept");

    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> next_thread <= pts_pkg::PRIO_W'(pts_pkg::THREAD_COUNT))
        else $error("pick out of range");

    // idle picked exactly when nothing is ready
    a_idle_pick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((next_thread == '0) == (ready_set == '0)))
        else $error("idle pick disagrees with ready mask");

    // picked thread is ready and nothing above it is
    a_pick_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && next_thread != '0
            |-> (ready_set >> (next_thread - pts_pkg::PRIO_W'(1))) == 1)
        else $error("pick is not the highest ready priority");

endmodule

bind priority_thread_scheduler pts_checker u_pts_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .next_thread    (out_ch.next_thread),
    .switch_request (out_ch.switch_request),
    .status         (out_ch.status),
    .ready_set      (out_ch.ready_set)
);
`default_nettype wire

### verif/priority_thread_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_thread_scheduler_tb
// self-checking bench for the bitmap thread scheduler: drives start, delay,
// tick and switch beats over valid/ready, tracks the scheduler state on the
// side and compares every result beat field by field, in order
// ----------------------------------------------------------------------------
module priority_thread_scheduler_tb;

    // one expected result beat
    typedef struct packed {
        pts_pkg::prio_t   next_thread;
        logic             switch_request;
        pts_pkg::status_t status;
        pts_pkg::mask_t   ready_set;
    } sched_report_t;

    // --------------------------------------------------------------------
    // scoreboard: keeps its own copy of the scheduler state, predicts the
    // report of every accepted action beat and checks reports in order
    // --------------------------------------------------------------------
    class sched_tracker;
        pts_pkg::mask_t   rdy_mask;
        pts_pkg::mask_t   blk_mask;
        logic [32:0]      used_prios;     // bit p set once priority p started
        pts_pkg::ticks_t  wait_left [pts_pkg::THREAD_COUNT];
        pts_pkg::prio_t   running;
        pts_pkg::prio_t   picked;

        sched_report_t  pending_reports [$];
        int             errors;
        int             beats_checked;
        int             action_count [4];
        int             status_count [4];
        int             max_blocked;
        int             wakeups;

        function new();
            rdy_mask      = '0;
            blk_mask      = '0;
            used_prios    = '0;
            running       = '0;
            picked        = '0;
            errors        = 0;
            beats_checked = 0;
            max_blocked   = 0;
            wakeups       = 0;
            for (int i = 0; i < 4; i++)
            begin
                action_count[i] = 0;
                status_count[i] = 0;
            end
            for (int i = 0; i < pts_pkg::THREAD_COUNT; i++)
            begin
                wait_left[i] = '0;
            end
        endfunction

        // top ready priority, scanning down from the highest bit
        function pts_pkg::prio_t top_ready(input pts_pkg::mask_t m);
            for (int i = pts_pkg::THREAD_COUNT - 1; i >= 0; i--)
            begin
                if (m[i])
                begin
                    return pts_pkg::prio_t'(i + 1);
                end
            end
            return '0;
        endfunction

        // an action beat was accepted: update state and queue its report
        function void note_action(input pts_pkg::action_t act, input pts_pkg::prio_t prio,
                                  input pts_pkg::ticks_t len);
            pts_pkg::status_t st;
            sched_report_t    rep;
            st = pts_pkg::ST_OK;
            case (act)
                pts_pkg::ACT_START:
                begin
                    // out of range priorities count as taken
                    if (prio > pts_pkg::THREAD_COUNT || used_prios[prio])
                    begin
                        st = pts_pkg::ST_IN_USE;
                    end
                    else
                    begin
                        used_prios[prio] = 1'b1;
                        if (prio != 0)
                        begin
                            rdy_mask[prio-1] = 1'b1;
                        end
                    end
                end
                pts_pkg::ACT_DELAY:
                begin
                    if (running == 0)
                    begin
                        st = pts_pkg::ST_IDLE_DELAY;
                    end
                    else if (len == 0)
                    begin
                        st = pts_pkg::ST_ZERO_TICKS;
                    end
                    else
                    begin
                        wait_left[running-1] = len;
                        rdy_mask[running-1]  = 1'b0;
                        blk_mask[running-1]  = 1'b1;
                    end
                end
                pts_pkg::ACT_TICK:
                begin
                    for (int i = 0; i < pts_pkg::THREAD_COUNT; i++)
                    begin
                        if (blk_mask[i])
                        begin
                            wait_left[i] = wait_left[i] - 1;
                            if (wait_left[i] == 0)
                            begin
                                rdy_mask[i] = 1'b1;
                                blk_mask[i] = 1'b0;
                                wakeups++;
                            end
                        end
                    end
                end
                default:
                begin
                    running = picked;
                end
            endcase
            picked = top_ready(rdy_mask);

            rep.next_thread    = picked;
            rep.switch_request = (picked != running);
            rep.status         = st;
            rep.ready_set      = rdy_mask;
            pending_reports.push_back(rep);

            action_count[act]++;
            status_count[st]++;
            if ($countones(blk_mask) > max_blocked)
            begin
                max_blocked = $countones(blk_mask);
            end
        endfunction

        // a report beat was accepted: compare with the oldest prediction
        function void check_result(input sched_report_t got);
            sched_report_t want;
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected report beat %p", $time, got);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            beats_checked++;
            if (got.next_thread !== want.next_thread)
            begin
                $display("%0t: next_thread expected %0d actual %0d",
                         $time, want.next_thread, got.next_thread);
                errors++;
            end
            if (got.switch_request !== want.switch_request)
            begin
                $display("%0t: switch_request expected %0b actual %0b",
                         $time, want.switch_request, got.switch_request);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.ready_set !== want.ready_set)
            begin
                $display("%0t: ready_set expected %h actual %h",
                         $time, want.ready_set, got.ready_set);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pts_in_if  in_ch ();
    pts_out_if out_ch ();

    sched_tracker sb;

    // idle chances in percent per cycle, changed between phases
    int send_idle_pct;
    int recv_idle_pct;

    priority_thread_scheduler u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side backpressure, redrawn every cycle
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // result monitor: values sampled at the edge are the pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            sb.check_result({out_ch.next_thread, out_ch.switch_request,
                             out_ch.status, out_ch.ready_set});
        end
    end

    // drive one action beat; valid stays high into the next call when there
    // is no gap, so it is never dropped and raised in the same step
    task automatic send_action(input pts_pkg::action_t act, input pts_pkg::prio_t prio,
                               input pts_pkg::ticks_t len);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.priority_req <= prio;
        in_ch.ticks        <= len;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        sb.note_action(act, prio, len);
    endtask

    // random beats: mostly scheduling traffic that keeps threads cycling
    // through ready, running and blocked, with bad starts and delays mixed in
    task automatic run_random(input int count);
        int               r;
        pts_pkg::action_t act;
        pts_pkg::prio_t   prio;
        pts_pkg::ticks_t  len;
        for (int k = 0; k < count; k++)
        begin
            r    = $urandom_range(0, 99);
            prio = pts_pkg::prio_t'($urandom_range(0, 63));
            len  = $urandom;
            if (r < 12)
            begin
                act = pts_pkg::ACT_START;
                r   = $urandom_range(0, 99);
                if (r < 60)
                begin
                    prio = pts_pkg::prio_t'($urandom_range(1, pts_pkg::THREAD_COUNT));
                end
                else if (r < 85)
                begin
                    prio = pts_pkg::prio_t'($urandom_range(pts_pkg::THREAD_COUNT + 1, 63));
                end
                else
                begin
                    prio = '0;
                end
            end
            else if (r < 42)
            begin
                act = pts_pkg::ACT_DELAY;
                r   = $urandom_range(0, 99);
                // short delays so blocked threads come back; a rare huge
                // one parks a thread for good
                if (r < 5)
                begin
                    len = '0;
                end
                else if (r < 75)
                begin
                    len = pts_pkg::ticks_t'($urandom_range(1, 4));
                end
                else if (r < 99)
                begin
                    len = pts_pkg::ticks_t'($urandom_range(5, 60));
                end
            end
            else if (r < 75)
            begin
                act = pts_pkg::ACT_TICK;
            end
            else
            begin
                act = pts_pkg::ACT_SWITCH;
            end
            send_action(act, prio, len);
        end
    endtask

    initial
    begin
        sb                 = new();
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.action       = pts_pkg::ACT_START;
        in_ch.priority_req = '0;
        in_ch.ticks        = '0;
        send_idle_pct      = 25;
        recv_idle_pct      = 79;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: delay from idle, with and without zero ticks
        send_action(pts_pkg::ACT_DELAY,  6'd0,  32'd0);
        send_action(pts_pkg::ACT_DELAY,  6'd0,  32'd5);
        // tick and switch with nothing started
        send_action(pts_pkg::ACT_TICK,   6'd63, 32'hFFFF_FFFF);
        send_action(pts_pkg::ACT_SWITCH, 6'd0,  32'd0);
        // idle thread registers but never gets ready, second start is taken
        send_action(pts_pkg::ACT_START,  6'd0,  32'd0);
        send_action(pts_pkg::ACT_START,  6'd0,  32'd0);
        // top priority, out of range ones, priority 1, then priority 32 again
        send_action(pts_pkg::ACT_START,  6'd32, 32'd0);
        send_action(pts_pkg::ACT_START,  6'd33, 32'd0);
        send_action(pts_pkg::ACT_START,  6'd63, 32'd0);
        send_action(pts_pkg::ACT_START,  6'd1,  32'd0);
        send_action(pts_pkg::ACT_START,  6'd32, 32'd0);
        // run priority 32, zero tick delay, then park it for good
        send_action(pts_pkg::ACT_SWITCH, 6'd0,  32'd0);
        send_action(pts_pkg::ACT_DELAY,  6'd0,  32'd0);
        send_action(pts_pkg::ACT_DELAY,  6'd0,  32'hFFFF_FFFF);
        // run priority 1, block it for two ticks while idle runs
        send_action(pts_pkg::ACT_SWITCH, 6'd0,  32'd0);
        send_action(pts_pkg::ACT_DELAY,  6'd0,  32'd2);
        send_action(pts_pkg::ACT_SWITCH, 6'd0,  32'd0);
        send_action(pts_pkg::ACT_TICK,   6'd0,  32'd0);
        send_action(pts_pkg::ACT_TICK,   6'd0,  32'd0);
        send_action(pts_pkg::ACT_SWITCH, 6'd0,  32'd0);
        // a middle priority preempts and is parked with an alternating length
        send_action(pts_pkg::ACT_START,  6'd16, 32'd0);
        send_action(pts_pkg::ACT_SWITCH, 6'd0,  32'd0);
        send_action(pts_pkg::ACT_DELAY,  6'd0,  32'h5555_5555);
        send_action(pts_pkg::ACT_SWITCH, 6'd0,  32'hAAAA_AAAA);

        // random traffic in three backpressure phases
        run_random(650);
        send_idle_pct = 79;
        recv_idle_pct = 25;
        run_random(650);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(650);
        in_ch.valid <= 1'b0;

        // drain, then leave room for a stray late beat after a tick
        while (sb.pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);

        $display("covered %0d start, %0d delay, %0d tick, %0d switch beats; %0d checked",
                 sb.action_count[pts_pkg::ACT_START], sb.action_count[pts_pkg::ACT_DELAY],
                 sb.action_count[pts_pkg::ACT_TICK], sb.action_count[pts_pkg::ACT_SWITCH],
                 sb.beats_checked);
        $display("in use %0d, idle delay %0d, zero ticks %0d; %0d wakeups, %0d max blocked",
                 sb.status_count[pts_pkg::ST_IN_USE], sb.status_count[pts_pkg::ST_IDLE_DELAY],
                 sb.status_count[pts_pkg::ST_ZERO_TICKS], sb.wakeups, sb.max_blocked);
        if (sb.errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
